[hw/rtl/tbrgs_pkg.sv]
// Shared types and constants for the row-gap text block segmenter.
package tbrgs_pkg;

	localparam int COORD_W = 12;
	localparam int OUT_W   = 14;
	localparam int PIX_W   = 8;
	localparam int GAP_W   = 8;
	localparam int MRG_W   = 4;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [COORD_W-1:0] COORD_MAX = '1;
	localparam logic [GAP_W-1:0]   RUN_MAX   = '1;

	localparam logic [PIX_W-1:0] THR_RESET = 8'd200;
	localparam logic [GAP_W-1:0] GAP_RESET = 8'd8;
	localparam logic [MRG_W-1:0] MRG_RESET = 4'd2;

	// Register indexes on paddr[3:2]
	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_GAP_LIMIT = 2'd1,
		REG_MARGIN    = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] fg_threshold;
		logic [GAP_W-1:0] gap_limit;
		logic [MRG_W-1:0] margin;
	} cfg_t;

endpackage

[hw/rtl/tbrgs_regs.sv]
// APB configuration registers of the segmenter.
module tbrgs_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tbrgs_pkg::ADDR_W-1:0] paddr,
	input  logic [tbrgs_pkg::DATA_W-1:0] pwdata,
	output logic [tbrgs_pkg::DATA_W-1:0] prdata,
	output logic                         pready,
	output tbrgs_pkg::cfg_t              cfg
);
	import tbrgs_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fg_threshold <= THR_RESET;
			cfg_q.gap_limit    <= GAP_RESET;
			cfg_q.margin       <= MRG_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_THRESHOLD: cfg_q.fg_threshold <= pwdata[PIX_W-1:0];
				REG_GAP_LIMIT: cfg_q.gap_limit    <= pwdata[GAP_W-1:0];
				REG_MARGIN:    cfg_q.margin       <= pwdata[MRG_W-1:0];
				REG_NONE:      ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (idx)
			REG_THRESHOLD: prdata = {{(DATA_W-PIX_W){1'b0}}, cfg_q.fg_threshold};
			REG_GAP_LIMIT: prdata = {{(DATA_W-GAP_W){1'b0}}, cfg_q.gap_limit};
			REG_MARGIN:    prdata = {{(DATA_W-MRG_W){1'b0}}, cfg_q.margin};
			REG_NONE:      prdata = '0;
		endcase
	end

endmodule

[hw/rtl/text_block_row_gap_segmenter.sv]
// Top level of the row-gap text block segmenter: input stage, box tracking, result register.
//
//  channel  | role         | signals                          | payload
//  ---------+--------------+----------------------------------+-----------------------------
//  s_*      | pixel in     | s_tvalid s_tready s_tdata        | pixel, tlast=row_end,
//           |              | s_tlast s_tuser                  | tuser=frame_end
//  m_*      | box out      | m_tvalid m_tready m_tdata        | left, top, right, bottom
//  APB      | config       | psel penable pwrite paddr ...    | fg_threshold, gap_limit, margin
//
// One pixel per clock while m_tready keeps the result register free; a pixel is held in the
// input register, and its box (if any) is loaded into the result register as the pixel advances.
// The input stage drains only when the result register is empty or being taken, so a
// stalled m_tready backs up into s_tready after one held pixel. Reset clears all
// counters, region extents and valid flags and loads the register defaults; no clearing pass.
module text_block_row_gap_segmenter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] pixel
	input  logic                         s_tlast,   // row_end
	input  logic                         s_tuser,   // frame_end
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [55:0]                  m_tdata,   // [13:0] left, [27:14] top,
	                                                // [41:28] right, [55:42] bottom
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tbrgs_pkg::ADDR_W-1:0] paddr,
	input  logic [tbrgs_pkg::DATA_W-1:0] pwdata,
	output logic [tbrgs_pkg::DATA_W-1:0] prdata,
	output logic                         pready
);
	import tbrgs_pkg::*;

	cfg_t cfg;

	tbrgs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input stage
	logic             vld_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             row_end_s1;
	logic             frame_end_s1;

	// Tracking state
	logic [COORD_W-1:0] column_count_q, row_count_q;
	logic [COORD_W-1:0] row_min_col_q, row_max_col_q;
	logic               row_has_fg_q;
	logic [COORD_W-1:0] reg_min_col_q, reg_max_col_q, reg_min_row_q, reg_max_row_q;
	logic               region_open_q;
	logic [GAP_W-1:0]   blank_run_q;

	// Result register
	logic             out_vld_q;
	logic [OUT_W-1:0] left_q, top_q, right_q, bottom_q;

	logic out_free, adv;

	assign out_free = ~out_vld_q | m_tready;
	assign adv      = vld_s1 & out_free;
	assign s_tready = ~vld_s1 | out_free;

	// Hold one pixel until the result side can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pix_s1       <= s_tdata;
			row_end_s1   <= s_tlast;
			frame_end_s1 <= s_tuser;
		end
	end

	// Next-state logic for one pixel
	logic               fg, line_end, emit, close_gap;
	logic [COORD_W-1:0] rmin_n, rmax_n;
	logic               rhas_n;
	logic [COORD_W-1:0] column_count_n, row_count_n;
	logic [COORD_W-1:0] row_min_col_n, row_max_col_n;
	logic               row_has_fg_n;
	logic [COORD_W-1:0] reg_min_col_n, reg_max_col_n, reg_min_row_n, reg_max_row_n;
	logic               region_open_n;
	logic [GAP_W-1:0]   blank_run_n;

	always_comb begin
		fg       = pix_s1 > cfg.fg_threshold;
		line_end = row_end_s1 | frame_end_s1;

		// grow the current row's column extent
		rmin_n = row_min_col_q;
		rmax_n = row_max_col_q;
		rhas_n = row_has_fg_q;
		if (fg) begin
			if (!row_has_fg_q) begin
				rmin_n = column_count_q;
				rmax_n = column_count_q;
				rhas_n = 1'b1;
			end else begin
				if (column_count_q < row_min_col_q) rmin_n = column_count_q;
				if (column_count_q > row_max_col_q) rmax_n = column_count_q;
			end
		end

		close_gap      = region_open_q & (blank_run_q > cfg.gap_limit);
		emit           = 1'b0;
		column_count_n = column_count_q;
		row_count_n    = row_count_q;
		row_min_col_n  = rmin_n;
		row_max_col_n  = rmax_n;
		row_has_fg_n   = rhas_n;
		reg_min_col_n  = reg_min_col_q;
		reg_max_col_n  = reg_max_col_q;
		reg_min_row_n  = reg_min_row_q;
		reg_max_row_n  = reg_max_row_q;
		region_open_n  = region_open_q;
		blank_run_n    = blank_run_q;

		if (line_end) begin
			// fold the finished row into the region
			if (rhas_n) begin
				if (close_gap || !region_open_q) begin
					emit          = close_gap;
					reg_min_col_n = rmin_n;
					reg_max_col_n = rmax_n;
					reg_min_row_n = row_count_q;
					reg_max_row_n = row_count_q;
					region_open_n = 1'b1;
				end else begin
					if (rmin_n < reg_min_col_q) reg_min_col_n = rmin_n;
					if (rmax_n > reg_max_col_q) reg_max_col_n = rmax_n;
					if (row_count_q < reg_min_row_q) reg_min_row_n = row_count_q;
					if (row_count_q > reg_max_row_q) reg_max_row_n = row_count_q;
				end
				blank_run_n = '0;
			end else if (region_open_q && blank_run_q != RUN_MAX) begin
				blank_run_n = blank_run_q + 1'b1;
			end

			if (frame_end_s1) begin
				// a gap after the region also closes it at frame end
				if (!rhas_n && region_open_q && (blank_run_n > cfg.gap_limit)) emit = 1'b1;
				column_count_n = '0;
				row_count_n    = '0;
				reg_min_col_n  = COORD_MAX;
				reg_max_col_n  = '0;
				reg_min_row_n  = COORD_MAX;
				reg_max_row_n  = '0;
				region_open_n  = 1'b0;
				blank_run_n    = '0;
			end else begin
				column_count_n = '0;
				if (row_count_q != COORD_MAX) row_count_n = row_count_q + 1'b1;
			end
			row_min_col_n = COORD_MAX;
			row_max_col_n = '0;
			row_has_fg_n  = 1'b0;
		end else if (column_count_q != COORD_MAX) begin
			column_count_n = column_count_q + 1'b1;
		end
	end

	// Advance the tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
			row_min_col_q  <= COORD_MAX;
			row_max_col_q  <= '0;
			row_has_fg_q   <= 1'b0;
			reg_min_col_q  <= COORD_MAX;
			reg_max_col_q  <= '0;
			reg_min_row_q  <= COORD_MAX;
			reg_max_row_q  <= '0;
			region_open_q  <= 1'b0;
			blank_run_q    <= '0;
		end else if (adv) begin
			column_count_q <= column_count_n;
			row_count_q    <= row_count_n;
			row_min_col_q  <= row_min_col_n;
			row_max_col_q  <= row_max_col_n;
			row_has_fg_q   <= row_has_fg_n;
			reg_min_col_q  <= reg_min_col_n;
			reg_max_col_q  <= reg_max_col_n;
			reg_min_row_q  <= reg_min_row_n;
			reg_max_row_q  <= reg_max_row_n;
			region_open_q  <= region_open_n;
			blank_run_q    <= blank_run_n;
		end
	end

	// Widen the old region by the margin; wraps in 14 bits
	logic [OUT_W-1:0] mrg_w;
	assign mrg_w = {{(OUT_W-MRG_W){1'b0}}, cfg.margin};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= emit;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			left_q   <= {{(OUT_W-COORD_W){1'b0}}, reg_min_col_q} - mrg_w;
			top_q    <= {{(OUT_W-COORD_W){1'b0}}, reg_min_row_q} - mrg_w;
			right_q  <= {{(OUT_W-COORD_W){1'b0}}, reg_max_col_q} + mrg_w;
			bottom_q <= {{(OUT_W-COORD_W){1'b0}}, reg_max_row_q} + mrg_w;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {bottom_q, right_q, top_q, left_q};

`ifndef SYNTHESIS
	// A pending box is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_tready) |-> !adv)
		else $error("pending box overwritten");

	// Frame end returns the tracker to its reset state
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && frame_end_s1) |=> (column_count_q == '0 && row_count_q == '0 &&
		!region_open_q && !row_has_fg_q))
		else $error("frame end did not clear state");

	// Blank rows are counted only behind an open region
	a_run_needs_region: assert property (@(posedge clk) disable iff (!arst_n)
		!region_open_q |-> (blank_run_q == '0))
		else $error("blank run without region");

	// A row end restarts the column count
	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && row_end_s1) |=> (column_count_q == '0 && !row_has_fg_q))
		else $error("row end did not restart columns");
`endif

endmodule

[tb/text_block_row_gap_segmenter_tb.sv]
// Testbench for the row-gap text block segmenter: stream and APB drivers, box predictor, checks.
`timescale 1ns / 1ps

module text_block_row_gap_segmenter_tb;
	import tbrgs_pkg::*;

	localparam int LIMIT        = 300000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 960;
	localparam int PHASES       = 8;
	localparam int SETTLE       = 4;

	typedef struct {
		logic [OUT_W-1:0] left;
		logic [OUT_W-1:0] top;
		logic [OUT_W-1:0] right;
		logic [OUT_W-1:0] bottom;
	} box_t;

	// Tracks row and region extents per pixel and queues the boxes the block must emit
	class region_box_model;
		cfg_t               cfg;
		logic [COORD_W-1:0] col, row;
		logic [COORD_W-1:0] row_lo, row_hi;
		logic               row_fg;
		logic [COORD_W-1:0] reg_lo_col, reg_hi_col, reg_lo_row, reg_hi_row;
		logic               reg_open;
		logic [GAP_W-1:0]   run;
		box_t               boxes_due[$];
		int                 mismatches;
		int                 boxes_seen;

		function new();
			cfg.fg_threshold = THR_RESET;
			cfg.gap_limit    = GAP_RESET;
			cfg.margin       = MRG_RESET;
			mismatches       = 0;
			boxes_seen       = 0;
			clear();
		endfunction

		function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_THRESHOLD: cfg.fg_threshold = val[PIX_W-1:0];
				REG_GAP_LIMIT: cfg.gap_limit    = val[GAP_W-1:0];
				REG_MARGIN:    cfg.margin       = val[MRG_W-1:0];
				default: ;
			endcase
		endfunction

		function void clear();
			col        = '0;
			row        = '0;
			row_lo     = COORD_MAX;
			row_hi     = '0;
			row_fg     = 1'b0;
			reg_lo_col = COORD_MAX;
			reg_hi_col = '0;
			reg_lo_row = COORD_MAX;
			reg_hi_row = '0;
			reg_open   = 1'b0;
			run        = '0;
		endfunction

		function void open_from_row();
			reg_lo_col = row_lo;
			reg_hi_col = row_hi;
			reg_lo_row = row;
			reg_hi_row = row;
			reg_open   = 1'b1;
		endfunction

		// Widen the region by margin; 14-bit arithmetic wraps below zero
		function void push_box();
			box_t             b;
			logic [OUT_W-1:0] m;
			m        = cfg.margin;
			b.left   = reg_lo_col - m;
			b.top    = reg_lo_row - m;
			b.right  = reg_hi_col + m;
			b.bottom = reg_hi_row + m;
			boxes_due = {boxes_due, b};
		endfunction

		function void take_pixel(logic [PIX_W-1:0] pix, logic row_end, logic frame_end);
			bit emitted;
			emitted = 1'b0;
			// grow the current row's column extent
			if (pix > cfg.fg_threshold) begin
				if (!row_fg) begin
					row_lo = col;
					row_hi = col;
					row_fg = 1'b1;
				end else begin
					if (col < row_lo) row_lo = col;
					if (col > row_hi) row_hi = col;
				end
			end
			if (row_end || frame_end) begin
				// close the row: split on a long gap, else merge or open
				if (row_fg) begin
					if (reg_open && run > cfg.gap_limit) begin
						push_box();
						emitted = 1'b1;
						open_from_row();
					end else if (reg_open) begin
						if (row_lo < reg_lo_col) reg_lo_col = row_lo;
						if (row_hi > reg_hi_col) reg_hi_col = row_hi;
						if (row < reg_lo_row) reg_lo_row = row;
						if (row > reg_hi_row) reg_hi_row = row;
					end else begin
						open_from_row();
					end
					run = '0;
				end else if (reg_open && run != RUN_MAX) begin
					run++;
				end
				if (frame_end) begin
					if (!emitted && reg_open && run > cfg.gap_limit) push_box();
					clear();
				end else begin
					row_lo = COORD_MAX;
					row_hi = '0;
					row_fg = 1'b0;
					col    = '0;
					if (row != COORD_MAX) row++;
				end
			end else if (col != COORD_MAX) begin
				col++;
			end
		endfunction

		function void check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
				mismatches++;
			end
		endfunction

		function void match_box(logic [4*OUT_W-1:0] d);
			box_t want;
			boxes_seen++;
			if (boxes_due.size() == 0) begin
				$error("box: expected none, got %h", d);
				mismatches++;
				return;
			end
			want = boxes_due.pop_front();
			check_field("left",   want.left,   d[0 +: OUT_W]);
			check_field("top",    want.top,    d[OUT_W +: OUT_W]);
			check_field("right",  want.right,  d[2*OUT_W +: OUT_W]);
			check_field("bottom", want.bottom, d[3*OUT_W +: OUT_W]);
		endfunction
	endclass

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata  = '0;   // [7:0] pixel
	logic              s_tlast  = 1'b0; // row_end
	logic              s_tuser  = 1'b0; // frame_end
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [55:0]       m_tdata;         // [13:0] left, [27:14] top, [41:28] right, [55:42] bottom
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [DATA_W-1:0] pwdata   = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	region_box_model boxes;
	int              cycles    = 0;
	int              pixels_in = 0;
	int              settings  = 0;
	int              hold_reqs = 0;
	int              hold_seen = 0;
	int              hold_left = 0;
	bit              quiet     = 1'b0;

	text_block_row_gap_segmenter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("text_block_row_gap_segmenter_tb: errors");
			$finish;
		end
	end

	// Receiver: random stalls, a long hold-off on request, none while quiet
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(99, 0) >= 6);
		end
	end

	// Predict on every input transfer, check every output transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				boxes.take_pixel(s_tdata, s_tlast, s_tuser);
				pixels_in++;
			end
			if (m_tvalid && m_tready) boxes.match_box(m_tdata);
		end
	end

	task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		boxes.set_reg(idx, val);
	endtask

	task automatic configure(int thr, int gap, int mrg);
		apb_write(REG_THRESHOLD, thr);
		apb_write(REG_GAP_LIMIT, gap);
		apb_write(REG_MARGIN, mrg);
		settings++;
	endtask

	// Offer one pixel, occasionally dropping valid ahead of it
	task automatic send(logic [7:0] pix, logic row_end, logic frame_end);
		if (!quiet && $urandom_range(99, 0) < 6) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata  <= pix;
		s_tlast  <= row_end;
		s_tuser  <= frame_end;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid, wait out every pending box, then let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (boxes.boxes_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [7:0] lo_pixel();
		return $urandom_range(int'(boxes.cfg.fg_threshold), 0);
	endfunction

	function automatic logic [7:0] hi_pixel();
		int thr;
		thr = boxes.cfg.fg_threshold;
		if (thr == 255) return lo_pixel();
		return $urandom_range(255, thr + 1);
	endfunction

	// One frame of text-like rows and blank runs around the gap limit, or pure noise
	task automatic random_frame();
		int   rows, w, fgc, blanks, cap, n;
		bit   fg, last_px;
		logic [7:0] pix;
		if ($urandom_range(7, 0) == 0) begin
			n = $urandom_range(40, 4);
			for (int i = 0; i < n; i++)
				send($urandom_range(255, 0), $urandom_range(3, 0) == 0,
					i == n - 1 || $urandom_range(59, 0) == 0);
			return;
		end
		cap    = int'(boxes.cfg.gap_limit) + 2;
		cap    = (cap > 12) ? 12 : cap;
		rows   = $urandom_range(24, 6);
		blanks = 0;
		for (int r = 0; r < rows; r++) begin
			fg = 1'b0;
			if (blanks > 0) blanks--;
			else if ($urandom_range(2, 0) == 0) blanks = $urandom_range(cap, 1) - 1;
			else fg = 1'b1;
			w   = ($urandom_range(19, 0) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
			fgc = $urandom_range(w - 1, 0);
			for (int c = 0; c < w; c++) begin
				pix     = (fg && (c == fgc || $urandom_range(3, 0) == 0)) ? hi_pixel() : lo_pixel();
				last_px = (r == rows - 1) && (c == w - 1);
				send(pix, (c == w - 1) && !(last_px && $urandom_range(1, 0) == 0), last_px);
			end
		end
	endtask

	// Corner cases at threshold 200, gap limit 0, margin 15
	task automatic directed();
		// foreground at columns 0 and 2; the threshold value itself is background
		send(8'd255, 1'b0, 1'b0);
		send(8'd200, 1'b0, 1'b0);
		send(8'd201, 1'b1, 1'b0);
		send(8'd0,   1'b1, 1'b0);
		// close the first region; left and top go negative
		send(8'd10,  1'b0, 1'b0);
		send(8'd255, 1'b1, 1'b0);
		send(8'd0,   1'b1, 1'b0);
		// foreground row ended by frame end alone, after a gap
		send(8'd255, 1'b0, 1'b1);
		// region reaching frame end with no gap is dropped
		send(8'd255, 1'b1, 1'b0);
		send(8'd254, 1'b1, 1'b1);
		// blank rows ahead of any region are not counted
		send(8'd0,   1'b1, 1'b0);
		send(8'd3,   1'b1, 1'b0);
		send(8'd255, 1'b1, 1'b0);
		send(8'd0,   1'b1, 1'b0);
		send(8'd0,   1'b1, 1'b1);
	endtask

	// Blank run past 255 behind an open region, closed at frame end
	task automatic tall_frame();
		repeat (3) send(8'd255, 1'b1, 1'b0);
		repeat (258) send(8'd0, 1'b1, 1'b0);
		send(8'd0, 1'b1, 1'b1);
	endtask

	initial begin
		int thr, gap, mrg, target;
		boxes = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(200, 0, 15);
		directed();
		settle();

		// Random phases across thresholds, gap limits and margins
		for (int ph = 0; ph < PHASES; ph++) begin
			thr = (ph == 0) ? 0 : (ph == 1) ? 255 : $urandom_range(254, 1);
			gap = (ph == 2) ? 0 : (ph == 5) ? 255 : $urandom_range(5, 0);
			mrg = (ph % 3 == 0) ? 15 : (ph % 3 == 1) ? 0 : $urandom_range(14, 1);
			configure(thr, gap, mrg);
			if (ph == 3) hold_reqs++;
			quiet  = (ph == 4);
			target = pixels_in + RANDOM_ITEMS / PHASES;
			while (pixels_in < target) random_frame();
			settle();
		end
		quiet = 1'b0;

		configure(128, 254, 15);
		tall_frame();
		settle();
		repeat (10) @(posedge clk);

		$display("Covered %0d pixels and %0d boxes over %0d register settings,",
			pixels_in, boxes.boxes_seen, settings);
		$display("including stalls, a long output hold-off and a saturated blank run.");
		if (boxes.mismatches == 0 && boxes.boxes_due.size() == 0) begin
			$display("text_block_row_gap_segmenter_tb: clean");
		end else begin
			$display("text_block_row_gap_segmenter_tb: errors");
		end
		$finish;
	end

endmodule

[text_block_row_gap_segmenter.f]
hw/rtl/tbrgs_pkg.sv
hw/rtl/tbrgs_regs.sv
hw/rtl/text_block_row_gap_segmenter.sv
tb/text_block_row_gap_segmenter_tb.sv
